FILE: rtl/mfrc_pkg.sv
// Shared types, constants and CRC function for the message frame receiver checker.
package mfrc_pkg;

   localparam logic [7:0]  MAGIC_BYTE      = 8'h56;
   localparam int          HDR_LEN_V2      = 24;
   localparam int          HDR_LEN_V1      = 20;
   localparam int          HDR_CRC_SPAN_V1 = 16;
   localparam int          QUEUE_DEPTH     = 4;
   localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
   localparam logic [1:0]  VER_NONE        = 2'd0;
   localparam logic [1:0]  VER_1           = 2'd1;
   localparam logic [1:0]  VER_2           = 2'd2;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_MAGIC   = 2'd1,
      ERR_HDR_CRC = 2'd2,
      ERR_PAY_CRC = 2'd3
   } error_type;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  version;
      error_type   error;
      logic        last;
      logic [7:0]  data;
      logic [15:0] command;
      logic [31:0] ident;
      logic [31:0] length;
      logic [2:0]  flags;
      logic [7:0]  ptype;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(logic [31:0] acc, logic [7:0] b);
      logic [31:0] c;
      c = acc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/mfrc_front.sv
// Front end: accepts bytes, tracks framing, checks CRCs and classifies results.
module mfrc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   output mfrc_pkg::push_type  push
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_HUNT    = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] snap_ff, snap_in;
   logic [31:0] rem_ff, rem_in;
   logic [1:0]  ver_ff, ver_in;
   logic [7:0]  hdr_ff [mfrc_pkg::HDR_LEN_V2];

   logic [4:0]  p;
   logic        hdr_we;
   logic [31:0] crc_upd;
   logic [31:0] be16_cur, be20_cur, be16_st, len_st;

   assign p        = (pos_ff >= 5'(mfrc_pkg::HDR_LEN_V2)) ? 5'd0 : pos_ff;
   assign crc_upd  = mfrc_pkg::crc_byte(crc_ff, rx_byte);
   assign be16_cur = {hdr_ff[16], hdr_ff[17], hdr_ff[18], rx_byte};
   assign be20_cur = {hdr_ff[20], hdr_ff[21], hdr_ff[22], rx_byte};
   assign be16_st  = {hdr_ff[16], hdr_ff[17], hdr_ff[18], hdr_ff[19]};
   assign len_st   = {hdr_ff[8], hdr_ff[9], hdr_ff[10], hdr_ff[11]};

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      snap_in  = snap_ff;
      rem_in   = rem_ff;
      ver_in   = ver_ff;
      hdr_we   = 1'b0;
      push.valid         = 1'b0;
      push.entry.kind    = mfrc_pkg::KIND_HEADER;
      push.entry.version = ver_ff;
      push.entry.error   = mfrc_pkg::ERR_NONE;
      push.entry.last    = 1'b0;
      push.entry.data    = rx_byte;
      push.entry.command = {hdr_ff[2], hdr_ff[3]};
      push.entry.ident   = {hdr_ff[4], hdr_ff[5], hdr_ff[6], hdr_ff[7]};
      push.entry.length  = len_st;
      push.entry.flags   = hdr_ff[12][2:0];
      push.entry.ptype   = hdr_ff[13];
      if (accept) begin
         if (phase_ff == PH_PAYLOAD) begin
            crc_in = crc_upd;
            rem_in = rem_ff - 32'd1;
            push.valid      = 1'b1;
            push.entry.kind = mfrc_pkg::KIND_PAYLOAD;
            if (rem_ff == 32'd1) begin
               push.entry.last = 1'b1;
               if (ver_ff == mfrc_pkg::VER_2 && ~crc_upd != be16_st) begin
                  push.entry.error = mfrc_pkg::ERR_PAY_CRC;
               end
               phase_in = PH_HEADER;
               pos_in   = 5'd0;
               crc_in   = mfrc_pkg::CRC_INIT;
            end
         end else if (!(phase_ff == PH_HUNT && rx_byte != mfrc_pkg::MAGIC_BYTE)) begin
            hdr_we   = 1'b1;
            phase_in = PH_HEADER;
            pos_in   = p + 5'd1;
            if (p < 5'(mfrc_pkg::HDR_LEN_V1)) begin
               crc_in = crc_upd;
            end
            if (p == 5'(mfrc_pkg::HDR_CRC_SPAN_V1 - 1)) begin
               snap_in = ~crc_upd;
            end
            if (p == 5'(mfrc_pkg::HDR_LEN_V1 - 1)) begin
               if (hdr_ff[0] != mfrc_pkg::MAGIC_BYTE ||
                   (hdr_ff[1] != 8'(mfrc_pkg::VER_1) && hdr_ff[1] != 8'(mfrc_pkg::VER_2))) begin
                  push.valid         = 1'b1;
                  push.entry.kind    = mfrc_pkg::KIND_ERROR;
                  push.entry.version = mfrc_pkg::VER_NONE;
                  push.entry.error   = mfrc_pkg::ERR_MAGIC;
                  phase_in = PH_HUNT;
                  pos_in   = 5'd0;
                  crc_in   = mfrc_pkg::CRC_INIT;
               end else begin
                  ver_in = hdr_ff[1][1:0];
                  if (hdr_ff[1][1:0] == mfrc_pkg::VER_1) begin
                     push.valid         = 1'b1;
                     push.entry.version = mfrc_pkg::VER_1;
                     pos_in = 5'd0;
                     crc_in = mfrc_pkg::CRC_INIT;
                     if (be16_cur != snap_ff) begin
                        push.entry.kind  = mfrc_pkg::KIND_ERROR;
                        push.entry.error = mfrc_pkg::ERR_HDR_CRC;
                        phase_in = PH_HUNT;
                     end else begin
                        push.entry.last = (len_st == 32'd0);
                        rem_in   = len_st;
                        phase_in = (len_st != 32'd0) ? PH_PAYLOAD : PH_HEADER;
                     end
                  end
               end
            end else if (p == 5'(mfrc_pkg::HDR_LEN_V2 - 1)) begin
               push.valid         = 1'b1;
               push.entry.version = mfrc_pkg::VER_2;
               pos_in = 5'd0;
               crc_in = mfrc_pkg::CRC_INIT;
               if (be20_cur != ~crc_ff) begin
                  push.entry.kind  = mfrc_pkg::KIND_ERROR;
                  push.entry.error = mfrc_pkg::ERR_HDR_CRC;
                  phase_in = PH_HUNT;
               end else begin
                  push.entry.last = (len_st == 32'd0);
                  rem_in   = len_st;
                  phase_in = (len_st != 32'd0) ? PH_PAYLOAD : PH_HEADER;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= 5'd0;
         crc_ff   <= mfrc_pkg::CRC_INIT;
         snap_ff  <= 32'd0;
         rem_ff   <= 32'd0;
         ver_ff   <= mfrc_pkg::VER_NONE;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         snap_ff  <= snap_in;
         rem_ff   <= rem_in;
         ver_ff   <= ver_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[p] <= rx_byte;
      end
   end

endmodule

FILE: rtl/mfrc_queue.sv
// Result queue between the front end and the output stage.
module mfrc_queue #(
   parameter int DEPTH = mfrc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  mfrc_pkg::push_type  push,
   input  logic                pop,
   output mfrc_pkg::entry_type head,
   output logic                empty,
   output logic                full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mfrc_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign empty   = (cnt_ff == CNT_W'(0));
   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push.entry;
      end
   end

endmodule

FILE: rtl/mfrc_back.sv
// Output stage: formats queued results per kind and holds them for the consumer.
module mfrc_back (
   input  logic                clock,
   input  logic                reset,
   input  mfrc_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [1:0]          rsp_result_kind,
   output logic [1:0]          rsp_frame_version,
   output logic [15:0]         rsp_command_code,
   output logic [31:0]         rsp_message_ident,
   output logic [31:0]         rsp_payload_length,
   output logic                rsp_payload_deflated,
   output logic                rsp_peer_compression,
   output logic                rsp_peer_msg_channel,
   output logic [7:0]          rsp_payload_kind,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_last_byte,
   output logic [1:0]          rsp_error_code
);

   logic                valid_ff;
   mfrc_pkg::entry_type out_ff, out_in;

   assign pop = !empty && (!valid_ff || !rsp_stall);

   always_comb begin
      out_in = head;
      unique case (head.kind)
         mfrc_pkg::KIND_HEADER: begin
            out_in.data = 8'd0;
         end
         mfrc_pkg::KIND_PAYLOAD: begin
            out_in.command = 16'd0;
            out_in.ident   = 32'd0;
            out_in.length  = 32'd0;
            out_in.flags   = 3'd0;
            out_in.ptype   = 8'd0;
         end
         default: begin
            out_in.last    = 1'b0;
            out_in.data    = 8'd0;
            out_in.command = 16'd0;
            out_in.ident   = 32'd0;
            out_in.length  = 32'd0;
            out_in.flags   = 3'd0;
            out_in.ptype   = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_result_kind      = out_ff.kind;
   assign rsp_frame_version    = out_ff.version;
   assign rsp_command_code     = out_ff.command;
   assign rsp_message_ident    = out_ff.ident;
   assign rsp_payload_length   = out_ff.length;
   assign rsp_payload_deflated = out_ff.flags[0];
   assign rsp_peer_compression = out_ff.flags[1];
   assign rsp_peer_msg_channel = out_ff.flags[2];
   assign rsp_payload_kind     = out_ff.ptype;
   assign rsp_data_byte        = out_ff.data;
   assign rsp_last_byte        = out_ff.last;
   assign rsp_error_code       = out_ff.error;

endmodule

FILE: rtl/message_frame_receiver_checker_unit.sv
// Message frame receiver checker: top level.
// Throughput: one byte per cycle unless req_stall (queue full) holds input; the CRC-32 is
// updated a byte per cycle in the front end, and the queue holds QUEUE_DEPTH results.
// A result is queued at its byte's accepting edge, then goes to the rsp_valid register.
// Header bytes before the last give no result, save a bad magic/version error at byte 20.
// Reset (synchronous) returns to header phase, clears the queue and the output register.
module message_frame_receiver_checker_unit #(
   parameter int QUEUE_DEPTH = mfrc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [1:0]  rsp_frame_version,
   output logic [15:0] rsp_command_code,
   output logic [31:0] rsp_message_ident,
   output logic [31:0] rsp_payload_length,
   output logic        rsp_payload_deflated,
   output logic        rsp_peer_compression,
   output logic        rsp_peer_msg_channel,
   output logic [7:0]  rsp_payload_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last_byte,
   output logic [1:0]  rsp_error_code
);

   mfrc_pkg::push_type  push;
   mfrc_pkg::entry_type head;
   logic                empty, full, pop, accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   mfrc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push)
   );

   mfrc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .empty (empty),
      .full  (full)
   );

   mfrc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .empty                (empty),
      .pop                  (pop),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_frame_version    (rsp_frame_version),
      .rsp_command_code     (rsp_command_code),
      .rsp_message_ident    (rsp_message_ident),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_payload_deflated (rsp_payload_deflated),
      .rsp_peer_compression (rsp_peer_compression),
      .rsp_peer_msg_channel (rsp_peer_msg_channel),
      .rsp_payload_kind     (rsp_payload_kind),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_last_byte        (rsp_last_byte),
      .rsp_error_code       (rsp_error_code)
   );

endmodule
